>>> rtl/dlle_pkg.sv
package dlle_pkg;

    // Default pool and list dimensions
    localparam int DEF_NODE_COUNT = 256;
    localparam int DEF_LIST_COUNT = 4;

    // Request code width
    localparam int OP_W = 4;

    // Request codes; unused codes behave as a query
    typedef enum logic [OP_W-1:0] {
        OP_CLEAR      = 4'd0,
        OP_PUSH_HEAD  = 4'd1,
        OP_PUSH_TAIL  = 4'd2,
        OP_INS_BEFORE = 4'd3,
        OP_INS_AFTER  = 4'd4,
        OP_REMOVE     = 4'd5,
        OP_POP_HEAD   = 4'd6,
        OP_POP_TAIL   = 4'd7,
        OP_SPLICE     = 4'd8,
        OP_ITER_START = 4'd9,
        OP_ITER_NEXT  = 4'd10,
        OP_QUERY      = 4'd11
    } dlle_op_t;

endpackage

>>> rtl/doubly_linked_list_engine_core.sv
// Sequence: an accepted request passes through a read step and two write steps before
//   its result is offered, longer while the previous result is still waiting to be taken.
// Requests: one at a time, taken only while idle, set by the single-ported link memories:
//   one read step, then two write steps per memory, sequenced by a four-state FSM.
// Reset: heads, tails and iterator cursors go to the null marker, counts to zero.
//   Link memories are not cleared; no clearing pass, requests are taken at once.
module doubly_linked_list_engine_core #(
    parameter int NODE_COUNT = dlle_pkg::DEF_NODE_COUNT,
    parameter int LIST_COUNT = dlle_pkg::DEF_LIST_COUNT,
    localparam int NODE_W = $clog2(NODE_COUNT),
    localparam int LIST_W = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1,
    localparam int LINK_W = $clog2(NODE_COUNT + 1)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [dlle_pkg::OP_W-1:0] op,
    input  logic [LIST_W-1:0]         list_id,
    input  logic [LIST_W-1:0]         source_list,
    input  logic [NODE_W-1:0]         node_index,
    input  logic [NODE_W-1:0]         position,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [NODE_W-1:0]         result_node,
    output logic                      result_valid,
    output logic                      list_is_empty,
    output logic [LINK_W-1:0]         list_count
);
    import dlle_pkg::*;

    localparam logic [LINK_W-1:0] NIL      = LINK_W'(NODE_COUNT);
    localparam logic [LIST_W-1:0] LIST_LIM = LIST_W'(LIST_COUNT);
    localparam logic [NODE_W-1:0] NODE_LIM = NODE_W'(NODE_COUNT);

    typedef struct packed {
        logic [LINK_W-1:0] head;
        logic [LINK_W-1:0] tail;
        logic [LINK_W-1:0] count;
        logic [LINK_W-1:0] cursor;
    } list_rec_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RDS,
        ST_WR1,
        ST_WR2
    } state_t;

    // Storage
    logic [LINK_W-1:0] next_mem [NODE_COUNT];
    logic [LINK_W-1:0] prev_mem [NODE_COUNT];
    list_rec_t         list_mem [LIST_COUNT];

    // Sequencer and request registers
    state_t            state_reg;
    dlle_op_t          op_reg;
    logic [LIST_W-1:0] l_reg;
    logic [LIST_W-1:0] s_reg;
    logic [NODE_W-1:0] node_reg;
    logic [NODE_W-1:0] pos_reg;
    list_rec_t         rec_l_reg;
    list_rec_t         rec_s_reg;
    logic [LINK_W-1:0] nxt_rd_reg;
    logic [LINK_W-1:0] prv_rd_reg;

    // Result register
    logic              out_valid_reg;
    logic [NODE_W-1:0] res_node_reg;
    logic              res_valid_reg;
    logic              empty_reg;
    logic [LINK_W-1:0] count_reg;

    // Combinational signals
    logic [LIST_W-1:0] l_in;
    logic [LIST_W-1:0] s_in;
    logic [NODE_W-1:0] n_in;
    logic [NODE_W-1:0] p_in;
    logic              out_free;
    logic              res_load;
    logic              wr_go;
    logic [LINK_W-1:0] n_l;
    logic [LINK_W-1:0] p_l;
    logic [LINK_W-1:0] victim;
    logic              unlink_ok;
    logic              splice_ok;
    logic [NODE_W-1:0] nxt_ra;
    logic [NODE_W-1:0] prv_ra;
    logic              nxt_wi;
    logic              prv_wi;
    logic [LINK_W-1:0] nxt_wa;
    logic [LINK_W-1:0] prv_wa;
    logic [LINK_W-1:0] nxt_wd;
    logic [LINK_W-1:0] prv_wd;
    logic              nxt_we;
    logic              prv_we;
    logic              lst_we;
    logic [LIST_W-1:0] lst_wa;
    list_rec_t         lst_wd;
    list_rec_t         rec_new;
    logic [NODE_W-1:0] res_node;
    logic              res_valid;

    // Fold out-of-range indices back into range
    assign l_in = (list_id >= LIST_LIM) ? list_id - LIST_LIM : list_id;
    assign s_in = (source_list >= LIST_LIM) ? source_list - LIST_LIM : source_list;
    assign n_in = (node_index >= NODE_LIM) ? node_index - NODE_LIM : node_index;
    assign p_in = (position >= NODE_LIM) ? position - NODE_LIM : position;

    assign in_ready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || out_ready;
    assign res_load = (state_reg == ST_WR2) && out_free;
    assign wr_go    = (state_reg == ST_WR1) || ((state_reg == ST_WR2) && out_free);

    assign n_l = LINK_W'(node_reg);
    assign p_l = LINK_W'(pos_reg);

    // Pick the node to unlink and the conditions for unlink and splice
    always_comb
    begin
        case (op_reg)
            OP_POP_HEAD: victim = rec_l_reg.head;
            OP_POP_TAIL: victim = rec_l_reg.tail;
            default:     victim = n_l;
        endcase
        unlink_ok = (op_reg == OP_REMOVE) ||
                    (((op_reg == OP_POP_HEAD) || (op_reg == OP_POP_TAIL)) && (victim < NIL));
        splice_ok = (s_reg != l_reg) && (rec_s_reg.head != NIL);
    end

    // Link read addresses for the read step
    always_comb
    begin
        nxt_ra = victim[NODE_W-1:0];
        prv_ra = victim[NODE_W-1:0];
        case (op_reg)
            OP_INS_BEFORE: prv_ra = pos_reg;
            OP_INS_AFTER:  nxt_ra = pos_reg;
            OP_ITER_NEXT:  nxt_ra = rec_l_reg.cursor[NODE_W-1:0];
            default:       nxt_ra = victim[NODE_W-1:0];
        endcase
    end

    // Link writes, first and second write steps
    always_comb
    begin
        nxt_wi = 1'b0;
        prv_wi = 1'b0;
        nxt_wa = n_l;
        prv_wa = n_l;
        nxt_wd = NIL;
        prv_wd = NIL;
        case (op_reg)
            OP_PUSH_HEAD:
            begin
                if (state_reg == ST_WR1)
                begin
                    prv_wi = 1'b1;
                    nxt_wi = 1'b1;
                    nxt_wd = rec_l_reg.head;
                end
                else
                begin
                    prv_wi = 1'b1;
                    prv_wa = rec_l_reg.head;
                    prv_wd = n_l;
                end
            end
            OP_PUSH_TAIL:
            begin
                if (state_reg == ST_WR1)
                begin
                    nxt_wi = 1'b1;
                    prv_wi = 1'b1;
                    prv_wd = rec_l_reg.tail;
                end
                else
                begin
                    nxt_wi = 1'b1;
                    nxt_wa = rec_l_reg.tail;
                    nxt_wd = n_l;
                end
            end
            OP_INS_BEFORE:
            begin
                nxt_wi = 1'b1;
                prv_wi = 1'b1;
                if (state_reg == ST_WR1)
                begin
                    nxt_wd = p_l;
                    prv_wd = prv_rd_reg;
                end
                else
                begin
                    nxt_wa = prv_rd_reg;
                    nxt_wd = n_l;
                    prv_wa = p_l;
                    prv_wd = n_l;
                end
            end
            OP_INS_AFTER:
            begin
                nxt_wi = 1'b1;
                prv_wi = 1'b1;
                if (state_reg == ST_WR1)
                begin
                    prv_wd = p_l;
                    nxt_wd = nxt_rd_reg;
                end
                else
                begin
                    prv_wa = nxt_rd_reg;
                    prv_wd = n_l;
                    nxt_wa = p_l;
                    nxt_wd = n_l;
                end
            end
            OP_REMOVE, OP_POP_HEAD, OP_POP_TAIL:
            begin
                nxt_wi = unlink_ok;
                prv_wi = unlink_ok;
                if (state_reg == ST_WR1)
                begin
                    nxt_wa = prv_rd_reg;
                    nxt_wd = nxt_rd_reg;
                    prv_wa = nxt_rd_reg;
                    prv_wd = prv_rd_reg;
                end
                else
                begin
                    nxt_wa = victim;
                    prv_wa = victim;
                end
            end
            OP_SPLICE:
            begin
                if (state_reg == ST_WR1)
                begin
                    nxt_wi = splice_ok && (rec_l_reg.tail != NIL);
                    prv_wi = splice_ok && (rec_l_reg.tail != NIL);
                    nxt_wa = rec_l_reg.tail;
                    nxt_wd = rec_s_reg.head;
                    prv_wa = rec_s_reg.head;
                    prv_wd = rec_l_reg.tail;
                end
            end
            default:
            begin
                nxt_wi = 1'b0;
                prv_wi = 1'b0;
            end
        endcase
        nxt_we = nxt_wi && (nxt_wa < NIL) && wr_go;
        prv_we = prv_wi && (prv_wa < NIL) && wr_go;
    end

    // New record of the named list and the result fields
    always_comb
    begin
        rec_new   = rec_l_reg;
        res_node  = '0;
        res_valid = 1'b0;
        case (op_reg)
            OP_CLEAR:
            begin
                rec_new.head   = NIL;
                rec_new.tail   = NIL;
                rec_new.count  = '0;
                rec_new.cursor = NIL;
            end
            OP_PUSH_HEAD:
            begin
                rec_new.head = n_l;
                if (rec_l_reg.head == NIL)
                begin
                    rec_new.tail = n_l;
                end
                rec_new.count = rec_l_reg.count + LINK_W'(1);
                res_node      = node_reg;
                res_valid     = 1'b1;
            end
            OP_PUSH_TAIL:
            begin
                rec_new.tail = n_l;
                if (rec_l_reg.tail == NIL)
                begin
                    rec_new.head = n_l;
                end
                rec_new.count = rec_l_reg.count + LINK_W'(1);
                res_node      = node_reg;
                res_valid     = 1'b1;
            end
            OP_INS_BEFORE:
            begin
                if (prv_rd_reg == NIL)
                begin
                    rec_new.head = n_l;
                end
                rec_new.count = rec_l_reg.count + LINK_W'(1);
                res_node      = node_reg;
                res_valid     = 1'b1;
            end
            OP_INS_AFTER:
            begin
                if (nxt_rd_reg == NIL)
                begin
                    rec_new.tail = n_l;
                end
                rec_new.count = rec_l_reg.count + LINK_W'(1);
                res_node      = node_reg;
                res_valid     = 1'b1;
            end
            OP_REMOVE, OP_POP_HEAD, OP_POP_TAIL:
            begin
                if (unlink_ok)
                begin
                    if (prv_rd_reg == NIL)
                    begin
                        rec_new.head = nxt_rd_reg;
                    end
                    if (nxt_rd_reg == NIL)
                    begin
                        rec_new.tail = prv_rd_reg;
                    end
                    rec_new.count = rec_l_reg.count - LINK_W'(1);
                    res_node      = victim[NODE_W-1:0];
                    res_valid     = 1'b1;
                end
            end
            OP_SPLICE:
            begin
                if (splice_ok)
                begin
                    if (rec_l_reg.tail == NIL)
                    begin
                        rec_new.head = rec_s_reg.head;
                    end
                    rec_new.tail  = rec_s_reg.tail;
                    rec_new.count = rec_l_reg.count + rec_s_reg.count;
                end
            end
            OP_ITER_START:
            begin
                rec_new.cursor = rec_l_reg.head;
            end
            OP_ITER_NEXT:
            begin
                if (rec_l_reg.cursor < NIL)
                begin
                    rec_new.cursor = nxt_rd_reg;
                    res_node       = rec_l_reg.cursor[NODE_W-1:0];
                    res_valid      = 1'b1;
                end
            end
            default:
            begin
                rec_new = rec_l_reg;
            end
        endcase
    end

    // List record writes: emptied splice source first, then the named list
    always_comb
    begin
        lst_we = 1'b0;
        lst_wa = l_reg;
        lst_wd = rec_new;
        if (state_reg == ST_WR1)
        begin
            lst_we = (op_reg == OP_SPLICE) && splice_ok;
            lst_wa = s_reg;
            lst_wd = '{head: NIL, tail: NIL, count: '0, cursor: rec_s_reg.cursor};
        end
        else if (state_reg == ST_WR2)
        begin
            lst_we = out_free;
        end
    end

    // Next link memory
    always_ff @(posedge clk)
    begin
        if (nxt_we)
        begin
            next_mem[nxt_wa[NODE_W-1:0]] <= nxt_wd;
        end
        if (state_reg == ST_RDS)
        begin
            nxt_rd_reg <= next_mem[nxt_ra];
        end
    end

    // Previous link memory
    always_ff @(posedge clk)
    begin
        if (prv_we)
        begin
            prev_mem[prv_wa[NODE_W-1:0]] <= prv_wd;
        end
        if (state_reg == ST_RDS)
        begin
            prv_rd_reg <= prev_mem[prv_ra];
        end
    end

    // List record file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LIST_COUNT; i++)
            begin
                list_mem[i] <= '{head: NIL, tail: NIL, count: '0, cursor: NIL};
            end
        end
        else if (lst_we)
        begin
            list_mem[lst_wa] <= lst_wd;
        end
    end

    // Sequencer, request capture and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // drop the result once its transaction completes
            if (out_valid_reg && out_ready && !res_load)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg    <= dlle_op_t'(op);
                        l_reg     <= l_in;
                        s_reg     <= s_in;
                        node_reg  <= n_in;
                        pos_reg   <= p_in;
                        rec_l_reg <= list_mem[l_in];
                        state_reg <= ST_RDS;
                    end
                end
                ST_RDS:
                begin
                    rec_s_reg <= list_mem[s_reg];
                    state_reg <= ST_WR1;
                end
                ST_WR1:
                begin
                    state_reg <= ST_WR2;
                end
                ST_WR2:
                begin
                    // hold until the result register is free
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        res_node_reg  <= res_node;
                        res_valid_reg <= res_valid;
                        empty_reg     <= (rec_new.head == NIL);
                        count_reg     <= rec_new.count;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_node   = res_node_reg;
    assign result_valid  = res_valid_reg;
    assign list_is_empty = empty_reg;
    assign list_count    = count_reg;

`ifndef SYNTH
    // An accepted request reaches its last write step through the read step and the first write step
    a_seq_timing: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> ##2 (state_reg == ST_WR2))
        else $error("request did not reach the final write step on time");

    // Link memories are written only in the write steps
    a_link_wr_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (nxt_we || prv_we) |-> ((state_reg == ST_WR1) || (state_reg == ST_WR2)))
        else $error("link memory written outside a write step");

    // A result without a node carries node zero
    a_no_node_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !result_valid) |-> (result_node == '0))
        else $error("result without a node carries a non-zero node");
`endif

endmodule
